### design/mstfb_pkg.sv
package mstfb_pkg;

  localparam int AXIS_COUNT = 5;
  localparam int AXIS_W = 32;

  localparam logic [3:0] OP_SLOT     = 4'd0;
  localparam logic [3:0] OP_TRACK    = 4'd1;
  localparam logic [3:0] OP_X        = 4'd2;
  localparam logic [3:0] OP_Y        = 4'd3;
  localparam logic [3:0] OP_PRESSURE = 4'd4;
  localparam logic [3:0] OP_MAJOR    = 4'd5;
  localparam logic [3:0] OP_MINOR    = 4'd6;
  localparam logic [3:0] OP_BUTTON   = 4'd7;
  localparam logic [3:0] OP_SYNC     = 4'd8;
  localparam logic [3:0] OP_DROPPED  = 4'd9;

  localparam logic [2:0] CS_MOTION = 3'd0;
  localparam logic [2:0] CS_TOUCH  = 3'd1;
  localparam logic [2:0] CS_DOWN   = 3'd2;
  localparam logic [2:0] CS_UP     = 3'd3;
  localparam logic [2:0] CS_CANCEL = 3'd4;
  localparam logic [2:0] CS_NONE   = 3'd5;

  localparam logic [2:0] REG_X_RANGE     = 3'd0;
  localparam logic [2:0] REG_Y_RANGE     = 3'd1;
  localparam logic [2:0] REG_PRESS_RANGE = 3'd2;
  localparam logic [2:0] REG_MAJOR_RANGE = 3'd3;
  localparam logic [2:0] REG_MINOR_RANGE = 3'd4;
  localparam logic [2:0] REG_AXIS_ENABLE = 3'd5;

  localparam logic [1:0] BSEL_MAX = 2'd2;

  // divider sequence: clamp, numerator, then 16 quotient bits
  localparam logic [4:0] NORM_CLAMP = 5'd1;
  localparam logic [4:0] NORM_PREP  = 5'd2;
  localparam logic [4:0] NORM_LAST  = 5'd18;

endpackage

### design/mstfb_norm.sv
module mstfb_norm import mstfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        enable,
  input  logic [31:0] value,
  input  logic [63:0] range,
  output logic        busy,
  output logic [15:0] result
);

  logic [4:0]         cnt;
  logic signed [31:0] vr, lo, hi, cl;
  logic               en, empty;
  logic [31:0]        d, den;
  logic [47:0]        rem, dsh;
  logic [15:0]        q;

  always_comb begin
    if (vr < lo) begin
      cl = lo;
    end else if (vr > hi) begin
      cl = hi;
    end else begin
      cl = vr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= NORM_CLAMP;
    end else if (cnt == NORM_LAST) begin
      cnt <= '0;
    end else if (cnt != '0) begin
      cnt <= cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vr <= value;
      lo <= range[31:0];
      hi <= range[63:32];
      en <= enable;
    end else if (cnt == NORM_CLAMP) begin
      empty <= !en || (hi <= lo);
      d     <= 32'(cl - lo);
      den   <= 32'(hi - lo);
    end else if (cnt == NORM_PREP) begin
      rem <= {d, 16'h0} - {16'h0, d};
      dsh <= {1'b0, den, 15'h0};
      q   <= '0;
    end else if (cnt != '0) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[14:0], 1'b1};
      end else begin
        q <= {q[14:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign busy   = (cnt != '0);
  assign result = empty ? 16'h0 : q;

endmodule

### design/multitouch_slot_frame_builder_unit.sv
// Slot and button events are handled on accept; axis writes read the row, then write it back (S_WR).
// Sync report: after the accept, count every slot (S_COUNT), decide (S_DECIDE), then scan the slots
// (S_SCAN); per contact: start, normalize, output (S_LOAD, S_DIV, S_PUT).
// Sync dropped: count, decide and scan as above, then one cancel word per contact from S_PUT;
// a buttons-only frame is one S_NONE output word; a stalled m_tready holds the output.
// rst (synchronous) clears registers, marks, selection, buttons; rows read as zero.
module multitouch_slot_frame_builder_unit import mstfb_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // event_value[31:0], button_select[33:32], forward_enable[34],
  // event_time[98:35], sink_accept[99], zero fill
  input  logic [103:0] s_tdata,
  // opcode[3:0]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // frame_time[63:0], button_bits[66:64], contact_total[71:67],
  // touching_total[76:72], contact_slot[80:77], pos_x[96:81], pos_y[112:97],
  // pressure_level[128:113], major_size[144:129], minor_size[160:145], zero fill
  output logic [167:0] m_tdata,
  // contact_state[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int RW = AXIS_COUNT * AXIS_W;
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WR     = 9'b000000010,
    S_COUNT  = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_LOAD   = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_PUT    = 9'b010000000,
    S_NONE   = 9'b100000000
  } state_t;

  state_t state;
  logic   finish;

  logic [63:0] axis_range [AXIS_COUNT];
  logic [2:0]  axis_enable;

  logic [RW-1:0] mem [SLOT_COUNT];
  logic [RW-1:0] rdata, row_new;
  logic [SW-1:0] rd_addr;

  logic [SLOT_COUNT-1:0] act, was, dirty, rv;
  logic [SW-1:0] sel, idx;
  logic          sel_valid;
  logic [2:0]    pb, pb_next;
  logic          bc;

  logic [CW-1:0] total, touching, em;
  logic          is_cancel, accept_r;
  logic [63:0]   time_r;
  logic [31:0]   val_r;
  logic [2:0]    fld;

  logic [3:0]  op;
  logic [31:0] ev;
  logic [1:0]  bsel;
  logic        fwd, acc;
  logic        take, out_ok, qual, is_last;

  logic [AXIS_COUNT-1:0] n_busy, n_en;
  logic [15:0]           n_res [AXIS_COUNT];
  logic [2:0]            cstate;
  logic [167:0]          word;

  assign op   = s_tuser;
  assign ev   = s_tdata[31:0];
  assign bsel = s_tdata[33:32];
  assign fwd  = s_tdata[34];
  assign acc  = s_tdata[99];

  assign s_tready  = (state == S_IDLE);
  assign take      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_ok    = !m_tvalid || m_tready;

  assign qual = is_cancel ? (act[idx] | was[idx]) : (dirty[idx] | (was[idx] & ~act[idx]));
  assign is_last = (CW'(em + 1'b1) == total);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        axis_range[i] <= '0;
      end
      axis_enable <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_RANGE, REG_Y_RANGE, REG_PRESS_RANGE, REG_MAJOR_RANGE, REG_MINOR_RANGE: begin
          axis_range[cfg_index] <= cfg_data;
        end
        REG_AXIS_ENABLE: axis_enable <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // slot rows: five axes of one slot per entry
  always_comb begin
    rd_addr = (state == S_IDLE) ? sel : idx;
    row_new = rv[sel] ? rdata : '0;
    row_new[fld*AXIS_W +: AXIS_W] = val_r;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (state == S_WR) begin
      mem[sel] <= row_new;
    end
  end

  always_comb begin
    pb_next = pb;
    if (ev != '0) begin
      pb_next = pb | (3'b001 << bsel);
    end else begin
      pb_next = pb & ~(3'b001 << bsel);
    end
  end

  assign n_en = {axis_enable, 2'b11};

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_norm
    mstfb_norm u_norm (
      .clk    (clk),
      .rst    (rst),
      .start  (state == S_LOAD),
      .enable (n_en[g]),
      .value  (rv[idx] ? rdata[g*AXIS_W +: AXIS_W] : 32'h0),
      .range  (axis_range[g]),
      .busy   (n_busy[g]),
      .result (n_res[g])
    );
  end

  always_comb begin
    if (is_cancel) begin
      cstate = CS_CANCEL;
    end else if (act[idx] && !was[idx]) begin
      cstate = CS_DOWN;
    end else if (!act[idx] && was[idx]) begin
      cstate = CS_UP;
    end else if (act[idx]) begin
      cstate = CS_TOUCH;
    end else begin
      cstate = CS_MOTION;
    end
    if (is_cancel) begin
      word = {7'h0, 80'h0, 4'(idx), 5'h0, 5'(total), pb, time_r};
    end else if (state == S_NONE) begin
      word = {7'h0, 80'h0, 4'h0, 5'(touching), 5'h0, pb, time_r};
    end else begin
      word = {7'h0, n_res[4], n_res[3], n_res[2], n_res[1], n_res[0], 4'(idx),
              5'(touching), 5'(total), pb, time_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_PUT || state == S_NONE) && out_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUT || state == S_NONE) && out_ok) begin
      m_tdata <= word;
      m_tuser <= (state == S_NONE) ? CS_NONE : cstate;
      m_tlast <= (state == S_NONE) ? 1'b1 : is_last;
    end
  end

  always_comb begin
    finish = 1'b0;
    if (state == S_NONE && out_ok) begin
      finish = 1'b1;
    end else if (state == S_PUT && out_ok && is_last) begin
      finish = 1'b1;
    end else if (state == S_SCAN && !qual && idx == LAST_IDX) begin
      finish = 1'b1;
    end else if (state == S_DECIDE && is_cancel && total == '0) begin
      finish = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      act       <= '0;
      was       <= '0;
      dirty     <= '0;
      rv        <= '0;
      sel       <= '0;
      sel_valid <= 1'b1;
      pb        <= '0;
      bc        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            time_r    <= s_tdata[98:35];
            accept_r  <= acc;
            val_r     <= ev;
            fld       <= 3'(op - OP_X);
            idx       <= '0;
            total     <= '0;
            touching  <= '0;
            em        <= '0;
            is_cancel <= (op == OP_DROPPED);
            unique case (op)
              OP_SLOT: begin
                if (ev[31] || ev >= 32'(SLOT_COUNT)) begin
                  sel_valid <= 1'b0;
                end else begin
                  sel       <= ev[SW-1:0];
                  sel_valid <= 1'b1;
                end
              end
              OP_TRACK: begin
                if (sel_valid) begin
                  act[sel]   <= !ev[31];
                  dirty[sel] <= 1'b1;
                end
              end
              OP_X, OP_Y, OP_PRESSURE, OP_MAJOR, OP_MINOR: begin
                if (sel_valid) begin
                  state <= S_WR;
                end
              end
              OP_BUTTON: begin
                if (bsel <= BSEL_MAX) begin
                  pb <= pb_next;
                  if (pb_next != pb) begin
                    bc <= 1'b1;
                  end
                end
              end
              OP_SYNC: begin
                if (fwd) begin
                  state <= S_COUNT;
                end else begin
                  dirty <= '0;
                  bc    <= 1'b0;
                end
              end
              OP_DROPPED: begin
                if (fwd) begin
                  state <= S_COUNT;
                end else begin
                  act       <= '0;
                  was       <= '0;
                  dirty     <= '0;
                  rv        <= '0;
                  sel       <= '0;
                  sel_valid <= 1'b1;
                  pb        <= '0;
                  bc        <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_WR: begin
          rv[sel]    <= 1'b1;
          dirty[sel] <= 1'b1;
          state      <= S_IDLE;
        end
        S_COUNT: begin
          if (qual) begin
            total <= total + 1'b1;
          end
          if (act[idx]) begin
            touching <= touching + 1'b1;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_DECIDE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DECIDE: begin
          if (total != '0) begin
            state <= S_SCAN;
          end else if (is_cancel) begin
            state <= S_IDLE;
          end else if (bc) begin
            state <= S_NONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (qual) begin
            state <= is_cancel ? S_PUT : S_LOAD;
          end else if (idx == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (n_busy == '0) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_ok) begin
            em <= em + 1'b1;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_NONE: begin
          if (out_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        if (is_cancel) begin
          act       <= '0;
          was       <= '0;
          dirty     <= '0;
          rv        <= '0;
          sel       <= '0;
          sel_valid <= 1'b1;
          pb        <= '0;
          bc        <= 1'b0;
        end else if (accept_r) begin
          was   <= act;
          dirty <= '0;
          bc    <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_wr_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> $past(state == S_IDLE))
    else $error("write-back without axis event");
  a_load_div: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |=> state == S_DIV)
    else $error("normalizer start lost");
  a_em_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && out_ok) |-> (em < total))
    else $error("more contacts than counted");
`endif

endmodule

### tb/testbench.sv
module testbench import mstfb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [63:0] frame_time;
    logic [2:0]  buttons;
    logic [4:0]  total;
    logic [4:0]  touching;
    logic [3:0]  slot;
    logic [2:0]  state;
    logic [15:0] x, y, p, ma, mi;
    logic        last;
  } contact_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] value;
    logic [1:0]  bsel;
    logic        fwd;
    logic [63:0] t;
    logic        accept;
  } event_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [167:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  multitouch_slot_frame_builder_unit u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] axis_range [5];
  logic [2:0]  axis_en;
  logic signed [31:0] sx [NSLOT], sy [NSLOT], sp [NSLOT], sma [NSLOT], smi [NSLOT];
  logic [2:0] sflag [NSLOT];
  logic [3:0] sel;
  logic sel_ok;
  logic [2:0] btns;
  logic btn_chg;

  contact_t pending [$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int send_idle = 30, recv_idle = 46;
  bit hold_off = 0;
  event_t table_rows [$];
  contact_t table_expect [$];

  function automatic logic [15:0] scale_axis(logic signed [31:0] v, logic [63:0] rng);
    longint lo, hi, c;
    lo = $signed(rng[31:0]);
    hi = $signed(rng[63:32]);
    c = v;
    if (hi <= lo) return 0;
    if (c < lo) c = lo;
    else if (c > hi) c = hi;
    return 16'(((c - lo) * 65535) / (hi - lo));
  endfunction

  task automatic clear_slots();
    for (int i = 0; i < NSLOT; i++) begin
      sx[i] = 0; sy[i] = 0; sp[i] = 0; sma[i] = 0; smi[i] = 0; sflag[i] = 0;
    end
    sel = 0; sel_ok = 1; btns = 0; btn_chg = 0;
  endtask

  task automatic track_event(event_t e);
    contact_t c;
    int total, touching, k;
    logic signed [31:0] v;
    logic act, was;
    v = e.value;
    case (e.op)
      OP_SLOT: begin
        if (v < 0 || v >= NSLOT) sel_ok = 0;
        else begin sel = v[3:0]; sel_ok = 1; end
      end
      OP_TRACK, OP_X, OP_Y, OP_PRESSURE, OP_MAJOR, OP_MINOR: begin
        if (sel_ok) begin
          case (e.op)
            OP_TRACK: sflag[sel][0] = (v >= 0);
            OP_X: sx[sel] = v;
            OP_Y: sy[sel] = v;
            OP_PRESSURE: sp[sel] = v;
            OP_MAJOR: sma[sel] = v;
            default: smi[sel] = v;
          endcase
          sflag[sel][2] = 1;
        end
      end
      OP_BUTTON: begin
        if (e.bsel <= BSEL_MAX) begin
          logic [2:0] old;
          old = btns;
          btns[e.bsel] = (v != 0);
          if (btns != old) btn_chg = 1;
        end
      end
      OP_SYNC: begin
        if (!e.fwd) begin
          for (int i = 0; i < NSLOT; i++) sflag[i][2] = 0;
          btn_chg = 0;
        end else begin
          total = 0; touching = 0; k = 0;
          for (int i = 0; i < NSLOT; i++) begin
            if (sflag[i][0]) touching++;
            if (sflag[i][2] || (sflag[i][1] && !sflag[i][0])) total++;
          end
          if (total > 0 || btn_chg) begin
            if (total == 0) begin
              c = '0;
              c.frame_time = e.t; c.buttons = btns; c.touching = 5'(touching);
              c.state = CS_NONE; c.last = 1;
              pending.push_back(c);
            end else begin
              for (int i = 0; i < NSLOT; i++) begin
                act = sflag[i][0]; was = sflag[i][1];
                if (!sflag[i][2] && !(was && !act)) continue;
                c = '0;
                c.frame_time = e.t; c.buttons = btns; c.total = 5'(total);
                c.touching = 5'(touching); c.slot = 4'(i);
                if (act && !was) c.state = CS_DOWN;
                else if (!act && was) c.state = CS_UP;
                else c.state = act ? CS_TOUCH : CS_MOTION;
                c.x = scale_axis(sx[i], axis_range[0]);
                c.y = scale_axis(sy[i], axis_range[1]);
                c.p = axis_en[0] ? scale_axis(sp[i], axis_range[2]) : 16'd0;
                c.ma = axis_en[1] ? scale_axis(sma[i], axis_range[3]) : 16'd0;
                c.mi = axis_en[2] ? scale_axis(smi[i], axis_range[4]) : 16'd0;
                k++;
                c.last = (k == total);
                pending.push_back(c);
              end
            end
            if (e.accept) begin
              for (int i = 0; i < NSLOT; i++) sflag[i] = sflag[i][0] ? 3'b011 : 3'b000;
              btn_chg = 0;
            end
          end
        end
      end
      OP_DROPPED: begin
        total = 0; k = 0;
        for (int i = 0; i < NSLOT; i++) if (sflag[i][1:0] != 0) total++;
        if (e.fwd && total > 0)
          for (int i = 0; i < NSLOT; i++)
            if (sflag[i][1:0] != 0) begin
              c = '0;
              c.frame_time = e.t; c.buttons = btns; c.total = 5'(total);
              c.slot = 4'(i); c.state = CS_CANCEL;
              k++;
              c.last = (k == total);
              pending.push_back(c);
            end
        clear_slots();
      end
      default: ;
    endcase
  endtask

  task automatic send_event(event_t e);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_tvalid = 1;
    s_tuser <= e.op;
    s_tdata <= {4'd0, e.accept, e.t, e.fwd, e.bsel, e.value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_event(e);
    sent++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_valid = 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_AXIS_ENABLE) axis_en = d[2:0];
    else axis_range[idx] = d;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic event_t mk(logic [3:0] op, logic [31:0] v, logic [1:0] b = 0,
                                logic f = 1, logic a = 1);
    event_t e;
    e.op = op; e.value = v; e.bsel = b; e.fwd = f; e.accept = a;
    e.t = {$urandom, $urandom};
    return e;
  endfunction

  function automatic logic [63:0] rand_range();
    int lo, span;
    lo = $urandom_range(2000) - 1000;
    span = $urandom_range(3) == 0 ? -$urandom_range(5) : $urandom_range(4000) + 1;
    return {32'(lo + span), 32'(lo)};
  endfunction

  function automatic event_t rand_noise();
    event_t e;
    e = mk(4'($urandom_range(15)), $urandom, 2'($urandom_range(3)),
           $urandom_range(3) != 0, $urandom_range(3) != 0);
    if ($urandom_range(3) == 0) e.value = $urandom_range(2300) - 1100;
    return e;
  endfunction

  // one touch frame: one to five slot updates, maybe a button event, then a sync report
  task automatic send_frame(int tag);
    int n;
    n = $urandom_range(4) + 1;
    for (int j = 0; j < n; j++) begin
      send_event(mk(OP_SLOT, $urandom_range(tag % 5 == 0 ? 17 : NSLOT - 1)));
      if ($urandom_range(2) == 0)
        send_event(mk(OP_TRACK, $urandom_range(2) == 0 ? -1 : $urandom_range(500)));
      send_event(mk(OP_X, $urandom_range(2400) - 1200));
      if ($urandom_range(1)) send_event(mk(OP_Y, $urandom_range(2400) - 1200));
      if ($urandom_range(2) == 0)
        send_event(mk(4'($urandom_range(OP_MINOR, OP_PRESSURE)), $urandom_range(3000) - 900));
    end
    if ($urandom_range(3) == 0)
      send_event(mk(OP_BUTTON, $urandom_range(1), 2'($urandom_range(2))));
    send_event(mk(OP_SYNC, 0, 0, $urandom_range(5) != 0, $urandom_range(4) != 0));
  endtask

  always @(negedge clk)
    if (!rst) m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[multitouch_slot_frame_builder_unit] ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      contact_t got, exp;
      got = {m_tdata[63:0], m_tdata[66:64], m_tdata[71:67], m_tdata[76:72], m_tdata[80:77],
             m_tuser, m_tdata[96:81], m_tdata[112:97], m_tdata[128:113], m_tdata[144:129],
             m_tdata[160:145], m_tlast};
      if (pending.size() == 0) begin
        $display("%0t unexpected word: got %h", $realtime, got);
        errors++;
      end else begin
        exp = pending.pop_front();
        if (got !== exp) begin
          $display("%0t mismatch: expected %h got %h", $realtime, exp, got);
          errors++;
        end
        if (table_expect.size() != 0 && (got.state == CS_CANCEL || got.state == CS_NONE)) begin
          contact_t te;
          te = table_expect.pop_front();
          if (got.state !== te.state || got.x !== te.x || got.total !== te.total) begin
            $display("%0t table mismatch: expected %h got %h", $realtime, te, got);
            errors++;
          end
        end
      end
    end
  end

  // long receiver stall so the input backs up
  initial begin
    wait (sent >= 100);
    hold_off = 1;
    repeat (3000) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    contact_t te;
    for (int i = 0; i < 5; i++) axis_range[i] = 0;
    axis_en = 0;
    clear_slots();
    repeat (6) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed rows; zero ranges read as 0
    table_rows = {mk(OP_BUTTON, 1, 0), mk(OP_SYNC, 0),
                  mk(OP_BUTTON, 1, 3), mk(4'd12, 32'h7fffffff),
                  mk(OP_SLOT, 0), mk(OP_TRACK, 5), mk(OP_X, 32'h7fffffff),
                  mk(OP_Y, 32'h80000000), mk(OP_SYNC, 0),
                  mk(OP_SLOT, 15), mk(OP_TRACK, 1), mk(OP_SYNC, 0, 0, 1, 0),
                  mk(OP_SLOT, -1), mk(OP_X, 5), mk(OP_SLOT, 16), mk(OP_Y, 3),
                  mk(OP_SYNC, 0, 0, 0), mk(OP_DROPPED, 0),
                  mk(OP_DROPPED, 0), mk(OP_BUTTON, 0, 2), mk(OP_SYNC, 0)};
    te = '0; te.state = CS_NONE; table_expect.push_back(te);
    te.state = CS_CANCEL; te.total = 2; table_expect.push_back(te); table_expect.push_back(te);
    foreach (table_rows[i]) send_event(table_rows[i]);
    drain();

    write_reg(REG_X_RANGE, {32'sd1000, -32'sd1000});
    write_reg(REG_Y_RANGE, {32'h7fffffff, 32'h80000000});
    write_reg(REG_PRESS_RANGE, {32'd0, 32'd0});
    write_reg(REG_MAJOR_RANGE, {32'd2000, 32'd0});
    write_reg(REG_MINOR_RANGE, {32'd10, 32'd20});
    write_reg(REG_AXIS_ENABLE, 3'b111);
    foreach (table_expect[i]) ;
    table_expect.delete();
    for (int i = 0; i < 4; i++) send_frame(i);
    send_event(mk(OP_DROPPED, 0));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 30 : ph == 1 ? 46 : 0;
      recv_idle = ph == 0 ? 46 : ph == 1 ? 30 : 0;
      for (int r = 0; r < 5; r++) write_reg(3'(r), rand_range());
      write_reg(REG_AXIS_ENABLE, ph == 2 ? 3'b000 : 3'($urandom_range(7)));
      for (int f = 0; f < 10; f++) begin
        if ($urandom_range(4) == 0) send_event(rand_noise());
        else send_frame(f);
        if ($urandom_range(9) == 0) send_event(mk(OP_DROPPED, 0, 0, $urandom_range(3) != 0));
      end
      drain();
    end

    if (errors == 0) $display("[multitouch_slot_frame_builder_unit] OK");
    else $display("[multitouch_slot_frame_builder_unit] ERROR");
    $finish;
  end
endmodule
